### rtl/core/rpx_pkg.sv
// Shared types, constants and trig table builder for the XYZ point rotator.
// Used by every module in rtl/core.
`default_nettype none
package rpx_pkg;

  localparam int ANGLE_BITS     = 12;
  localparam int COORD_BITS     = 8;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int QSTEPS    = 1 << (ANGLE_BITS - 2);
  localparam int SIN_DEPTH = QSTEPS + 1;
  localparam int DW        = COORD_BITS + TRIG_FRAC_BITS + 2;
  localparam int PW        = DW + TRIG_FRAC_BITS + 2;
  localparam int SW        = PW + 1;
  localparam int ROT_W     = 17;
  localparam int SCR_W     = 8;
  localparam int OUT_SHIFT = TRIG_FRAC_BITS - 8;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [SCR_W-1:0] CENTER_X_RST = 8'd64;
  localparam logic [SCR_W-1:0] CENTER_Y_RST = 8'd32;

  // ceil(2^64 / ((2n)(2n+1))) for the Taylor terms n = 1..9
  localparam logic [127:0] TWO64 = 128'd1 << 64;
  localparam logic [127:0] RECIP [9] = '{
    (TWO64 + 128'd5) / 128'd6,
    (TWO64 + 128'd19) / 128'd20,
    (TWO64 + 128'd41) / 128'd42,
    (TWO64 + 128'd71) / 128'd72,
    (TWO64 + 128'd109) / 128'd110,
    (TWO64 + 128'd155) / 128'd156,
    (TWO64 + 128'd209) / 128'd210,
    (TWO64 + 128'd271) / 128'd272,
    (TWO64 + 128'd341) / 128'd342
  };

  typedef logic [ANGLE_BITS-1:0]        angle_t;
  typedef logic [ANGLE_BITS-2:0]        rom_addr_t;
  typedef logic [TRIG_FRAC_BITS:0]      sin_mag_t;
  typedef logic signed [TRIG_FRAC_BITS+1:0] trig_t;
  typedef logic signed [DW-1:0]         coord_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         sum_t;
  typedef logic signed [ROT_W-1:0]      rot_t;
  typedef logic [SCR_W-1:0]             scr_t;
  typedef sin_mag_t sin_tbl_t [SIN_DEPTH];

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic {
    CFG_CENTER_X = 1'b0,
    CFG_CENTER_Y = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t ax;
    angle_t ay;
    angle_t az;
  } rot_item_t;

  function automatic sin_mag_t quarter_sine(int k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] sum;
    logic [127:0] w;
    int s;
    x = (64'(k) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
    t = x;
    sum = x;
    for (int n = 1; n <= 9; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      w = 128'(t) * RECIP[n - 1];
      t = w[127:64];
      if (n % 2 == 1) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
    end
    s = 30 - TRIG_FRAC_BITS;
    sum = (sum + (64'd1 << (s - 1))) >> s;
    if (sum > (64'd1 << TRIG_FRAC_BITS)) begin
      sum = 64'd1 << TRIG_FRAC_BITS;
    end
    return sin_mag_t'(sum);
  endfunction

  function automatic sin_tbl_t sin_table();
    sin_tbl_t tb;
    for (int k = 0; k < SIN_DEPTH; k++) begin
      tb[k] = quarter_sine(k);
    end
    return tb;
  endfunction

  function automatic rom_addr_t sin_addr(angle_t a);
    rom_addr_t idx;
    idx = rom_addr_t'(a[ANGLE_BITS-3:0]);
    if (a[ANGLE_BITS-2]) begin
      return rom_addr_t'(QSTEPS) - idx;
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rotate_point_xyz_project.sv
// Top level of the XYZ Euler point rotator: input register, three rotation cells, output stage.
// Depends on rpx_pkg, rpx_cell and rpx_out.
//
//   port group   direction  handshake         contents
//   command      in         start / busy      vertex_x/y/z, angle_x/y/z
//   result       out        done (1 cycle)    rot_x/y/z, screen_x/y, off_screen
//   config       in         cfg_we            cfg_addr, cfg_data
//
// One item per clock; each result passes through the input register, the three rotation cells
// and the output stage.
// busy stays low; results cannot be held off.
// rst clears the pipeline valid bits and loads the centre offsets.
`default_nettype none
module rotate_point_xyz_project (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire signed [7:0]     vertex_x,
  input  wire signed [7:0]     vertex_y,
  input  wire signed [7:0]     vertex_z,
  input  wire [11:0]           angle_x,
  input  wire [11:0]           angle_y,
  input  wire [11:0]           angle_z,
  input  wire                  cfg_we,
  input  wire                  cfg_addr,
  input  wire [7:0]            cfg_data,
  output logic                 done,
  output logic signed [16:0]   rot_x,
  output logic signed [16:0]   rot_y,
  output logic signed [16:0]   rot_z,
  output logic [7:0]           screen_x,
  output logic [7:0]           screen_y,
  output logic                 off_screen
);
  import rpx_pkg::*;

  scr_t      center_x;
  scr_t      center_y;
  rot_item_t i0, c1, c2, c3;
  rot_item_t i0_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    i0_next.valid = start && !busy;
    i0_next.x = coord_t'(vertex_x) <<< TRIG_FRAC_BITS;
    i0_next.y = coord_t'(vertex_y) <<< TRIG_FRAC_BITS;
    i0_next.z = coord_t'(vertex_z) <<< TRIG_FRAC_BITS;
    i0_next.ax = angle_x;
    i0_next.ay = angle_y;
    i0_next.az = angle_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i0 <= '0;
    end else begin
      i0 <= i0_next;
    end
  end

  rpx_cell u_cell_x (.clk(clk), .rst(rst), .axis(AXIS_X), .in_item(i0), .out_item(c1));
  rpx_cell u_cell_y (.clk(clk), .rst(rst), .axis(AXIS_Y), .in_item(c1), .out_item(c2));
  rpx_cell u_cell_z (.clk(clk), .rst(rst), .axis(AXIS_Z), .in_item(c2), .out_item(c3));

  rpx_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_item    (c3),
    .center_x   (center_x),
    .center_y   (center_y),
    .done       (done),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .rot_z      (rot_z),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .off_screen (off_screen)
  );

endmodule
`default_nettype wire

### rtl/core/rpx_sin_rom.sv
// Quarter-wave sine table with two registered read ports.
// Depends on rpx_pkg for the table builder and widths.
`default_nettype none
module rpx_sin_rom (
  input  wire                 clk,
  input  rpx_pkg::rom_addr_t  addr_a,
  input  rpx_pkg::rom_addr_t  addr_b,
  output rpx_pkg::sin_mag_t   data_a,
  output rpx_pkg::sin_mag_t   data_b
);
  import rpx_pkg::*;

  localparam sin_tbl_t TBL = sin_table();

  always_ff @(posedge clk) begin
    data_a <= TBL[addr_a];
    data_b <= TBL[addr_b];
  end

endmodule
`default_nettype wire

### rtl/core/rpx_cell.sv
// One rotation cell: looks up sin/cos of its axis angle and rotates one coordinate pair.
// Depends on rpx_pkg and rpx_sin_rom.
`default_nettype none
module rpx_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  rpx_pkg::axis_t      axis,
  input  rpx_pkg::rot_item_t  in_item,
  output rpx_pkg::rot_item_t  out_item
);
  import rpx_pkg::*;

  localparam sum_t RND = sum_t'(1) <<< (TRIG_FRAC_BITS - 1);

  angle_t    ang;
  angle_t    ang_c;
  rot_item_t i1, i2, i3, i4;
  rot_item_t i4_next;
  logic      sneg1, cneg1;
  sin_mag_t  smag, cmag;
  trig_t     s2, c2;
  coord_t    p, q;
  prod_t     pc, qs, ps, qc;
  sum_t      sa, sb;
  coord_t    na, nb;

  always_comb begin
    case (axis)
      AXIS_X:  ang = in_item.ax;
      AXIS_Y:  ang = in_item.ay;
      AXIS_Z:  ang = in_item.az;
      default: ang = in_item.ax;
    endcase
    ang_c = ang + angle_t'(QSTEPS);
  end

  rpx_sin_rom u_rom (
    .clk    (clk),
    .addr_a (sin_addr(ang)),
    .addr_b (sin_addr(ang_c)),
    .data_a (smag),
    .data_b (cmag)
  );

  always_comb begin
    case (axis)
      AXIS_X:  begin p = i2.y; q = i2.z; end
      AXIS_Y:  begin p = i2.x; q = i2.z; end
      AXIS_Z:  begin p = i2.x; q = i2.y; end
      default: begin p = i2.y; q = i2.z; end
    endcase
    sa = sum_t'(pc) - sum_t'(qs) + RND;
    sb = sum_t'(ps) + sum_t'(qc) + RND;
    na = coord_t'(sa >>> TRIG_FRAC_BITS);
    nb = coord_t'(sb >>> TRIG_FRAC_BITS);
    i4_next = i3;
    case (axis)
      AXIS_X:  begin i4_next.y = na; i4_next.z = nb; end
      AXIS_Y:  begin i4_next.x = na; i4_next.z = nb; end
      AXIS_Z:  begin i4_next.x = na; i4_next.y = nb; end
      default: begin i4_next.y = na; i4_next.z = nb; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i1 <= '0;
      i2 <= '0;
      i3 <= '0;
      i4 <= '0;
    end else begin
      i1 <= in_item;
      i2 <= i1;
      i3 <= i2;
      i4 <= i4_next;
    end
    sneg1 <= ang[ANGLE_BITS-1];
    cneg1 <= ang_c[ANGLE_BITS-1];

    s2 <= sneg1 ? -trig_t'(smag) : trig_t'(smag);
    c2 <= cneg1 ? -trig_t'(cmag) : trig_t'(cmag);

    pc <= prod_t'(p) * prod_t'(c2);
    qs <= prod_t'(q) * prod_t'(s2);
    ps <= prod_t'(p) * prod_t'(s2);
    qc <= prod_t'(q) * prod_t'(c2);
  end

  assign out_item = i4;

endmodule
`default_nettype wire

### rtl/core/rpx_out.sv
// Output stage: rounds to Q.8, saturates, and maps x and y to screen coordinates.
// Depends on rpx_pkg.
`default_nettype none
module rpx_out (
  input  wire                 clk,
  input  wire                 rst,
  input  rpx_pkg::rot_item_t  in_item,
  input  rpx_pkg::scr_t       center_x,
  input  rpx_pkg::scr_t       center_y,
  output logic                done,
  output rpx_pkg::rot_t       rot_x,
  output rpx_pkg::rot_t       rot_y,
  output rpx_pkg::rot_t       rot_z,
  output rpx_pkg::scr_t       screen_x,
  output rpx_pkg::scr_t       screen_y,
  output logic                off_screen
);
  import rpx_pkg::*;

  localparam coord_t RND8 = (OUT_SHIFT > 0) ? (coord_t'(1) <<< (OUT_SHIFT - 1)) : coord_t'(0);
  localparam coord_t RMAX = coord_t'(65535);
  localparam coord_t RMIN = -coord_t'(65536);

  logic   v1;
  rot_t   rx1, ry1, rz1;
  coord_t tx, ty, tz;
  logic signed [9:0] px, py;

  function automatic rot_t sat(coord_t v);
    if (v > RMAX) begin
      return rot_t'(RMAX);
    end
    if (v < RMIN) begin
      return rot_t'(RMIN);
    end
    return rot_t'(v);
  endfunction

  always_comb begin
    tx = (in_item.x + RND8) >>> OUT_SHIFT;
    ty = (in_item.y + RND8) >>> OUT_SHIFT;
    tz = (in_item.z + RND8) >>> OUT_SHIFT;
    px = 10'(signed'(rx1[16:8])) + signed'({2'b00, center_x});
    py = 10'(signed'(ry1[16:8])) + signed'({2'b00, center_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_item.valid;
      done <= v1;
    end
    rx1 <= sat(tx);
    ry1 <= sat(ty);
    rz1 <= sat(tz);
    rot_x <= rx1;
    rot_y <= ry1;
    rot_z <= rz1;
    screen_x <= (px < 0) ? scr_t'(0) : (px > 10'sd255) ? scr_t'(255) : scr_t'(px);
    screen_y <= (py < 0) ? scr_t'(0) : (py > 10'sd255) ? scr_t'(255) : scr_t'(py);
    off_screen <= (px < 0) || (px > 10'sd255) || (py < 0) || (py > 10'sd255);
  end

endmodule
`default_nettype wire
